[src/nsp_pkg.sv]
// Shared types and constants for the nearest segment pick/delete block.
// No dependencies; imported by every module under src.
package nsp_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned ENTRY_W     = 4 * COORD_W;
  localparam int unsigned SQ_W        = 2 * COORD_W + 1;   // dx^2 + dy^2
  localparam int unsigned FRAC_SH     = 16;                // Q.8 squared
  localparam int unsigned ROOT_W      = COORD_W + 9;       // Q.8 length
  localparam int unsigned RAD_W       = 2 * ROOT_W;
  localparam int unsigned ROOT_CNT_W  = $clog2(ROOT_W + 1);
  localparam int unsigned DIFF_W      = ROOT_W + 1;
  localparam int unsigned PCT         = 25600;             // 100.0 in Q.8
  localparam int unsigned PCT_W       = 15;
  localparam int unsigned NUM_W       = DIFF_W + PCT_W;
  localparam int unsigned NUM_CNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned ERR_W       = 22;
  localparam int unsigned ERR_LIMIT   = 2560000;           // 10000.0 in Q.8
  localparam int unsigned BOX_GROW    = 2;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_PICK     = 2'd1,
    OP_PICK_DEL = 2'd2,
    OP_CLEAR    = 2'd3
  } nsp_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } nsp_status_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] seg_start_x;
    logic [COORD_W-1:0] seg_start_y;
    logic [COORD_W-1:0] seg_end_x;
    logic [COORD_W-1:0] seg_end_y;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } nsp_cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] picked_index;
    logic [ERR_W-1:0] pick_error;
    logic [CNT_W-1:0] segment_count;
  } nsp_res_t;

endpackage

[src/nsp_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
// Depends on nsp_pkg.
module nsp_isqrt import nsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W+1:0]     rem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic                  busy_q, done_q;

  logic [ROOT_W+3:0] rem_n, trial, rem_sub;
  logic              ge;

  assign rem_n   = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial   = (ROOT_W+4)'({root_q, 2'b01});
  assign ge      = (rem_n >= trial);
  assign rem_sub = rem_n - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ROOT_CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ROOT_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[ROOT_W+1:0] : rem_n[ROOT_W+1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[src/nsp_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nsp_pkg.
module nsp_div import nsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quot_o
);

  logic [NUM_W-1:0]     num_q;
  logic [ROOT_W-1:0]    rem_q, den_q;
  logic [NUM_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  logic [ROOT_W:0] rem_n, rem_sub;
  logic            ge;

  assign rem_n   = {rem_q, num_q[NUM_W-1]};
  assign ge      = (rem_n >= {1'b0, den_q});
  assign rem_sub = rem_n - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= NUM_CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NUM_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[ROOT_W-1:0] : rem_n[ROOT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[src/nearest_segment_pick_delete_core.sv]
// Top level: segment table, command sequencer, pick scan.
// Depends on nsp_pkg, nsp_isqrt, nsp_div.

// A command beat is taken when start_i is high and busy_o is low. Every
// command returns exactly one result beat, shown on res_o for one cycle with
// done_o high; the receiver cannot stall it, so capture it when it appears.
// Append and clear answer in the cycle after the beat. A pick walks the table
// one slot at a time: a slot whose grown bounding box misses the point only
// passes through fetch, evaluate and next; a candidate also runs the shared
// bit-serial square root (three lengths, cut short if the segment length is
// zero) and the bit-serial divider for the percent error. Pick-and-delete adds
// a fetch and a write for the move of the last slot when one is picked. Table
// contents after reset are undefined; only slots below the count are ever used.
module nearest_segment_pick_delete_core import nsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  nsp_cmd_t cmd_i,
  output logic     busy_o,
  output logic     done_o,
  output nsp_res_t res_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_EVAL, S_SQ, S_WAIT_SQ, S_MUL, S_WAIT_DIV,
    S_NEXT, S_FIN, S_DFETCH, S_DWRITE
  } state_e;

  state_e           state_q;
  nsp_cmd_t         cmd_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] idx_q, best_q, rd_addr_q;
  logic [ERR_W-1:0] best_err_q;
  logic             found_q;
  logic [1:0]       k_q;           // which length: segment, start, end
  logic [ENTRY_W-1:0] seg_q;
  logic [ROOT_W-1:0]  len_q, d0_q;
  logic [DIFF_W-1:0]  diff_q;
  logic [RAD_W-1:0]   rad_q;
  logic [NUM_W-1:0]   num_q;
  logic               sq_start_q, div_start_q, done_q;
  nsp_res_t           res_q;

  // table
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_addr_q];
  end

  // serial units
  logic              sq_done, div_done;
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  quot;

  nsp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_q),
    .rad_i   (rad_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  nsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num_q),
    .den_i   (len_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // entry fields: {sx, sy, ex, ey}
  logic [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
  logic [COORD_W-1:0] s_sx, s_sy, s_ex, s_ey;
  assign {r_sx, r_sy, r_ex, r_ey} = rdata_q;
  assign {s_sx, s_sy, s_ex, s_ey} = seg_q;

  // grown bounding box test on the freshly read slot
  logic [COORD_W:0] lox, hix, loy, hiy, pxg, pyg, pxe, pye;
  logic             in_box;
  always_comb begin
    lox = {1'b0, (r_sx < r_ex) ? r_sx : r_ex};
    hix = {1'b0, (r_sx < r_ex) ? r_ex : r_sx};
    loy = {1'b0, (r_sy < r_ey) ? r_sy : r_ey};
    hiy = {1'b0, (r_sy < r_ey) ? r_ey : r_sy};
    pxe = {1'b0, cmd_q.point_x};
    pye = {1'b0, cmd_q.point_y};
    pxg = pxe + (COORD_W+1)'(BOX_GROW);
    pyg = pye + (COORD_W+1)'(BOX_GROW);
    in_box = !((pxg < lox) || (pxe > hix + (COORD_W+1)'(BOX_GROW)) ||
               (pyg < loy) || (pye > hiy + (COORD_W+1)'(BOX_GROW)));
  end

  // endpoints of the length in work
  logic [COORD_W-1:0] ax, ay, bx, by, dx, dy;
  logic [SQ_W-1:0]    sq_sum;
  always_comb begin
    case (k_q)
      2'd0: begin
        ax = s_sx; ay = s_sy; bx = s_ex; by = s_ey;
      end
      2'd1: begin
        ax = cmd_q.point_x; ay = cmd_q.point_y; bx = s_sx; by = s_sy;
      end
      default: begin
        ax = cmd_q.point_x; ay = cmd_q.point_y; bx = s_ex; by = s_ey;
      end
    endcase
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    sq_sum = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
  end

  // |d0 + d1 - L|
  logic [DIFF_W-1:0] dsum, lext, diff;
  always_comb begin
    dsum = {1'b0, d0_q} + {1'b0, root};
    lext = {1'b0, len_q};
    diff = (dsum > lext) ? dsum - lext : lext - dsum;
  end

  logic [CNT_W-1:0] idx_nx;
  logic [IDX_W-1:0] last_idx;
  assign idx_nx   = {1'b0, idx_q} + 1'b1;
  assign last_idx = IDX_W'(count_q - 1'b1);

  // table writes: append, or the move of the last slot on delete
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr_q;
    mem_wdata = rdata_q;
    case (state_q)
      S_IDLE: begin
        mem_we    = start_i && (nsp_op_e'(cmd_i.opcode) == OP_APPEND) &&
                    (count_q != CNT_W'(TABLE_DEPTH));
        mem_waddr = IDX_W'(count_q);
        mem_wdata = {cmd_i.seg_start_x, cmd_i.seg_start_y,
                     cmd_i.seg_end_x, cmd_i.seg_end_y};
      end
      S_DWRITE: begin
        mem_we    = (best_q != last_idx);
        mem_waddr = best_q;
        mem_wdata = rdata_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      done_q      <= 1'b0;
      sq_start_q  <= 1'b0;
      div_start_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      rd_addr_q   <= '0;
      k_q         <= '0;
    end else begin
      done_q      <= 1'b0;
      sq_start_q  <= 1'b0;
      div_start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q <= cmd_i;
            res_q <= '0;
            case (nsp_op_e'(cmd_i.opcode))
              OP_APPEND: begin
                done_q <= 1'b1;
                if (count_q == CNT_W'(TABLE_DEPTH)) begin
                  res_q.status        <= ST_FULL;
                  res_q.segment_count <= count_q;
                end else begin
                  count_q             <= count_q + 1'b1;
                  res_q.segment_count <= count_q + 1'b1;
                end
              end
              OP_CLEAR: begin
                done_q  <= 1'b1;
                count_q <= '0;
              end
              default: begin
                found_q    <= 1'b0;
                best_q     <= '0;
                best_err_q <= ERR_W'(ERR_LIMIT);
                idx_q      <= '0;
                rd_addr_q  <= '0;
                if (count_q == '0) begin
                  done_q       <= 1'b1;
                  res_q.status <= ST_NONE;
                end else begin
                  state_q <= S_FETCH;
                end
              end
            endcase
          end
        end
        S_FETCH: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          seg_q <= rdata_q;
          k_q   <= 2'd0;
          state_q <= in_box ? S_SQ : S_NEXT;
        end
        S_SQ: begin
          rad_q      <= RAD_W'({sq_sum, FRAC_SH'(0)});
          sq_start_q <= 1'b1;
          state_q    <= S_WAIT_SQ;
        end
        S_WAIT_SQ: begin
          if (sq_done) begin
            case (k_q)
              2'd0: begin
                len_q   <= root;
                k_q     <= 2'd1;
                state_q <= (root == '0) ? S_NEXT : S_SQ;
              end
              2'd1: begin
                d0_q    <= root;
                k_q     <= 2'd2;
                state_q <= S_SQ;
              end
              default: begin
                diff_q  <= diff;
                state_q <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          num_q       <= NUM_W'(diff_q) * NUM_W'(PCT);
          div_start_q <= 1'b1;
          state_q     <= S_WAIT_DIV;
        end
        S_WAIT_DIV: begin
          if (div_done) begin
            if (quot < NUM_W'(best_err_q)) begin
              best_err_q <= quot[ERR_W-1:0];
              best_q     <= idx_q;
              found_q    <= 1'b1;
            end
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (idx_nx == count_q) begin
            state_q <= S_FIN;
          end else begin
            idx_q     <= idx_nx[IDX_W-1:0];
            rd_addr_q <= idx_nx[IDX_W-1:0];
            state_q   <= S_FETCH;
          end
        end
        S_FIN: begin
          res_q.segment_count <= count_q;
          if (!found_q) begin
            res_q.status <= ST_NONE;
            done_q       <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            res_q.picked_index <= best_q;
            res_q.pick_error   <= best_err_q;
            if (nsp_op_e'(cmd_q.opcode) == OP_PICK_DEL) begin
              rd_addr_q <= last_idx;
              state_q   <= S_DFETCH;
            end else begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        S_DFETCH: begin
          state_q <= S_DWRITE;
        end
        S_DWRITE: begin
          count_q             <= count_q - 1'b1;
          res_q.segment_count <= count_q - 1'b1;
          done_q              <= 1'b1;
          state_q             <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // every result beat lands with the block idle again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result beat while busy");

  // an accepted command either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o)) else $error("command dropped");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH)) else $error("segment count overflow");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_NONE) |->
      (res_o.picked_index == '0 && res_o.pick_error == '0))
    else $error("no-pick result carries index or error");

endmodule

[test/tb_top.sv]
// Testbench for nearest_segment_pick_delete_core: directed table, full table,
// then random command mix; every result beat checked against an in-bench table model or a hand-typed result.
// Depends on nsp_pkg and the core under src.
`timescale 1ns / 1ps

module tb_top;
  import nsp_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  nsp_cmd_t cmd_i;
  logic     busy_o;
  logic     done_o;
  nsp_res_t res_o;

  nearest_segment_pick_delete_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Segment table model: our own copy of the table and the count.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] tbl_x0 [TABLE_DEPTH];
  logic [COORD_W-1:0] tbl_y0 [TABLE_DEPTH];
  logic [COORD_W-1:0] tbl_x1 [TABLE_DEPTH];
  logic [COORD_W-1:0] tbl_y1 [TABLE_DEPTH];
  int unsigned        held;

  nsp_res_t     pending_res[$];   // results owed by the core, oldest first
  int unsigned  fail_cnt;

  // Floor integer square root, digit-by-digit.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q.8 distance between two points.
  function automatic longint unsigned dist_q8(int ax, int ay, int bx, int by);
    longint unsigned dx;
    longint unsigned dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return floor_root((dx * dx + dy * dy) << 16);
  endfunction

  // Apply one command to the table model and return the result it owes.
  function automatic nsp_res_t run_command(nsp_cmd_t c);
    nsp_res_t        r;
    longint unsigned best_err;
    longint unsigned len, d0, d1, sum, diff, err;
    int              best, px, py, sx, sy, ex, ey;
    bit              found;
    r        = '0;
    best_err = ERR_LIMIT;
    best     = 0;
    found    = 1'b0;
    px       = c.point_x;
    py       = c.point_y;
    case (c.opcode)
      OP_APPEND: begin
        if (held >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_x0[held] = c.seg_start_x;
          tbl_y0[held] = c.seg_start_y;
          tbl_x1[held] = c.seg_end_x;
          tbl_y1[held] = c.seg_end_y;
          held++;
        end
      end
      OP_CLEAR: held = 0;
      default: begin
        for (int i = 0; i < held; i++) begin
          sx = tbl_x0[i];
          sy = tbl_y0[i];
          ex = tbl_x1[i];
          ey = tbl_y1[i];
          // grown bounding box must hold the point
          if (px + BOX_GROW < ((sx < ex) ? sx : ex)) continue;
          if (px > ((sx < ex) ? ex : sx) + BOX_GROW) continue;
          if (py + BOX_GROW < ((sy < ey) ? sy : ey)) continue;
          if (py > ((sy < ey) ? ey : sy) + BOX_GROW) continue;
          len = dist_q8(sx, sy, ex, ey);
          if (len == 0) continue;  // degenerate segment never wins
          d0   = dist_q8(px, py, sx, sy);
          d1   = dist_q8(px, py, ex, ey);
          sum  = d0 + d1;
          diff = (sum > len) ? sum - len : len - sum;
          err  = (diff * PCT) / len;
          if (err < best_err) begin  // strict: first of equals keeps it
            best_err = err;
            best     = i;
            found    = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NONE;
        end else begin
          r.picked_index = IDX_W'(best);
          r.pick_error   = ERR_W'(best_err);
          if (c.opcode == OP_PICK_DEL) begin
            // last slot fills the hole; deleting the last just shrinks
            tbl_x0[best] = tbl_x0[held-1];
            tbl_y0[best] = tbl_y0[held-1];
            tbl_x1[best] = tbl_x1[held-1];
            tbl_y1[best] = tbl_y1[held-1];
            held--;
          end
        end
      end
    endcase
    r.segment_count = CNT_W'(held);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
    fail_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor. The core cannot be stalled, so every done_o beat is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    nsp_res_t want;
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        $display("%0t result beat with nothing outstanding", $realtime);
        fail_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (res_o.status !== want.status)
          report_mismatch("status", res_o.status, want.status);
        if (res_o.picked_index !== want.picked_index)
          report_mismatch("picked_index", res_o.picked_index, want.picked_index);
        if (res_o.pick_error !== want.pick_error)
          report_mismatch("pick_error", res_o.pick_error, want.pick_error);
        if (res_o.segment_count !== want.segment_count)
          report_mismatch("segment_count", res_o.segment_count, want.segment_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver with bursty pacing.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;

  // Hold the command until the core takes it; log what it owes.
  task automatic send_beat(nsp_cmd_t c, bit use_typed, nsp_res_t typed);
    nsp_res_t r;
    if (burst_left == 0) begin
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start_i <= 1'b1;
    cmd_i   <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = run_command(c);
    pending_res.push_back(use_typed ? typed : r);
  endtask

  function automatic nsp_cmd_t mk_cmd(nsp_op_e op, int sx, int sy, int ex, int ey,
                                      int px, int py);
    nsp_cmd_t c;
    c.opcode      = op;
    c.seg_start_x = COORD_W'(sx);
    c.seg_start_y = COORD_W'(sy);
    c.seg_end_x   = COORD_W'(ex);
    c.seg_end_y   = COORD_W'(ey);
    c.point_x     = COORD_W'(px);
    c.point_y     = COORD_W'(py);
    return c;
  endfunction

  function automatic nsp_res_t mk_res(nsp_status_e st, int idx, int err, int cnt);
    nsp_res_t r;
    r.status        = st;
    r.picked_index  = IDX_W'(idx);
    r.pick_error    = ERR_W'(err);
    r.segment_count = CNT_W'(cnt);
    return r;
  endfunction

  // Fully random command word, every field filled.
  function automatic nsp_cmd_t rand_word();
    return nsp_cmd_t'($bits(nsp_cmd_t)'({$urandom(), $urandom()}));
  endfunction

  // Directed stimulus table; typed rows carry a result read off by hand.
  typedef struct {
    nsp_cmd_t cmd;
    bit       typed;
    nsp_res_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(nsp_cmd_t c, bit typed, nsp_res_t r = '0);
    dir_row_t d;
    d.cmd   = c;
    d.typed = typed;
    d.res   = r;
    dir_rows.push_back(d);
  endtask

  // Mostly a short segment with random placement; keeps candidate scans cheap.
  function automatic nsp_cmd_t rand_segment();
    nsp_cmd_t c;
    int       sx, sy;
    c = rand_word();
    c.opcode = OP_APPEND;
    if ($urandom_range(0, 9) == 0) return c;  // any size, any place
    sx = $urandom_range(0, 1023);
    sy = $urandom_range(0, 1023);
    c.seg_start_x = COORD_W'(sx);
    c.seg_start_y = COORD_W'(sy);
    c.seg_end_x   = COORD_W'(sx + $urandom_range(0, 48) - 24);
    c.seg_end_y   = COORD_W'(sy + $urandom_range(0, 48) - 24);
    return c;
  endfunction

  // Pick near a held segment most of the time, anywhere otherwise.
  function automatic nsp_cmd_t rand_pick(nsp_op_e op);
    nsp_cmd_t c;
    int       k, t, bx, by;
    c = rand_word();
    c.opcode = op;
    if (held != 0 && $urandom_range(0, 4) != 0) begin
      k  = $urandom_range(0, held - 1);
      t  = $urandom_range(0, 4);
      bx = (tbl_x0[k] * (4 - t) + tbl_x1[k] * t) / 4;
      by = (tbl_y0[k] * (4 - t) + tbl_y1[k] * t) / 4;
      c.point_x = COORD_W'(bx + $urandom_range(0, 6) - 3);
      c.point_y = COORD_W'(by + $urandom_range(0, 6) - 3);
    end
    return c;
  endfunction

  initial begin
    nsp_cmd_t c;
    int       roll;
    held       = 0;
    fail_cnt   = 0;
    burst_left = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    cmd_i      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 0, 0), 1, mk_res(ST_NONE, 0, 0, 0));
    add_row(mk_cmd(OP_PICK_DEL, 1023, 1023, 1023, 1023, 1023, 1023), 1,
            mk_res(ST_NONE, 0, 0, 0));
    add_row(mk_cmd(OP_APPEND, 0, 0, 1023, 1023, 0, 0), 1, mk_res(ST_OK, 0, 0, 1));
    // point on an endpoint of the diagonal: zero error
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 1023, 1023), 1, mk_res(ST_OK, 0, 0, 1));
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 1));
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 1023, 0), 0);
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 511, 513), 0);
    // zero-length segment is never picked, even with the point on it
    add_row(mk_cmd(OP_APPEND, 500, 500, 500, 500, 0, 0), 1, mk_res(ST_OK, 0, 0, 2));
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 500, 500), 0);
    add_row(mk_cmd(OP_CLEAR, 1023, 1023, 1023, 1023, 1023, 1023), 1,
            mk_res(ST_OK, 0, 0, 0));
    add_row(mk_cmd(OP_APPEND, 500, 500, 500, 500, 0, 0), 1, mk_res(ST_OK, 0, 0, 1));
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 500, 500), 1, mk_res(ST_NONE, 0, 0, 1));
    add_row(mk_cmd(OP_APPEND, 1023, 0, 0, 1023, 0, 0), 0);
    add_row(mk_cmd(OP_APPEND, 10, 20, 40, 20, 0, 0), 0);
    add_row(mk_cmd(OP_APPEND, 12, 18, 38, 22, 0, 0), 0);
    // just outside the grown box, then just inside its corner
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 43, 25), 0);
    add_row(mk_cmd(OP_PICK, 0, 0, 0, 0, 42, 24), 0);
    add_row(mk_cmd(OP_PICK_DEL, 0, 0, 0, 0, 25, 20), 0);
    add_row(mk_cmd(OP_PICK_DEL, 0, 0, 0, 0, 25, 20), 0);
    add_row(mk_cmd(OP_PICK_DEL, 0, 0, 0, 0, 1023, 0), 0);
    add_row(mk_cmd(OP_PICK_DEL, 0, 0, 0, 0, 700, 300), 0);
    add_row(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 0));
    foreach (dir_rows[i]) send_beat(dir_rows[i].cmd, dir_rows[i].typed,
                                    dir_rows[i].res);

    // drain fully once before the random part
    start_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);

    // --- full table: fill every slot, get refused, then pick and delete ---
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      c = mk_cmd(OP_APPEND, (i * 4) & 10'h3ff, (i / 256) * 40 + (i % 7) * 100,
                 (i * 4 + 3) & 10'h3ff, (i / 256) * 40 + (i % 7) * 100 + 2, 0, 0);
      send_beat(c, 0, '0);
    end
    send_beat(rand_segment(), 0, '0);
    send_beat(rand_segment(), 0, '0);
    for (int i = 0; i < 10; i++) send_beat(rand_pick(OP_PICK_DEL), 0, '0);
    send_beat(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0), 0, '0);

    // --- random part ---
    for (int n = 0; n < 1000; n++) begin
      if (n == 500) begin
        // let everything drain before going on
        start_i    <= 1'b0;
        burst_left = 0;
        while (pending_res.size() != 0) @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      if (held > 40 && roll < 8) begin
        c = rand_word();
        c.opcode = OP_CLEAR;
      end else if (roll < 2) begin
        c = rand_word();
        c.opcode = OP_CLEAR;
      end else if (roll < 47 || held == 0 && roll < 80) begin
        c = rand_segment();
      end else if (roll < 77) begin
        c = rand_pick(OP_PICK);
      end else begin
        c = rand_pick(OP_PICK_DEL);
      end
      send_beat(c, 0, '0);
    end

    start_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    repeat (20_000_000) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
